// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the mixer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SVM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SVM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ===== rtl/svm_pkg.sv =====
// Shared types, widths and constants of the stereo voice mix accumulator.
package svm_pkg;

	localparam int SLOT_W       = 9;
	localparam int SAMPLE_W     = 16;
	localparam int VOL_W        = 9;
	localparam int OUT_W        = 16;
	localparam int ACC_W        = 32;
	localparam int ADD_W        = 17;
	localparam int PROD_W       = ACC_W + VOL_W + 1;
	localparam int PAINT_SIZE_DEF = 512;
	localparam int QUEUE_DEPTH  = 4;

	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 9;

	localparam logic [CFG_IDX_W-1:0] REG_MASTER_VOLUME = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SWAP_STEREO   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_BYTES  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MONO_OUTPUT   = 2'd3;

	localparam logic [VOL_W-1:0] MASTER_RESET = 9'd179;

	localparam logic OP_MIX   = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	localparam logic [7:0] BYTE_GAIN_CAP  = 8'd255;
	localparam logic [7:0] BYTE_GAIN_MASK = 8'hf8;
	localparam logic [7:0] BYTE_BIAS      = 8'h80;

	localparam int SAT_HI = 32767;
	localparam int SAT_LO = -32768;
	localparam logic [OUT_W-1:0] SAT_MAX = 16'h7fff;
	localparam logic [OUT_W-1:0] SAT_MIN = 16'h8000;

	typedef struct packed {
		logic [VOL_W-1:0] master_volume;
		logic             swap_stereo;
		logic             output_bytes;
		logic             mono_output;
	} svm_cfg_t;

	// One classified item on its way from the front end to the back end.
	typedef struct packed {
		logic                    op;
		logic signed [ADD_W-1:0] add_l;
		logic signed [ADD_W-1:0] add_r;
	} svm_work_t;

endpackage

// ===== rtl/svm_intf.sv =====
// Channel interfaces of the mixer: item input, result output, register writes.
interface svm_in_if;
	logic                                 valid;
	logic                                 ready;
	logic                                 op;
	logic [svm_pkg::SLOT_W-1:0]           slot;
	logic signed [svm_pkg::SAMPLE_W-1:0]  sample;
	logic                                 sample_is_byte;
	logic [svm_pkg::VOL_W-1:0]            left_volume;
	logic [svm_pkg::VOL_W-1:0]            right_volume;

	modport source (output valid, op, slot, sample, sample_is_byte, left_volume,
		right_volume, input ready);
	modport sink (input valid, op, slot, sample, sample_is_byte, left_volume,
		right_volume, output ready);
endinterface

interface svm_out_if;
	logic                              valid;
	logic                              ready;
	logic signed [svm_pkg::OUT_W-1:0]  left_out;
	logic signed [svm_pkg::OUT_W-1:0]  right_out;

	modport source (output valid, left_out, right_out, input ready);
	modport sink (input valid, left_out, right_out, output ready);
endinterface

interface svm_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [svm_pkg::CFG_IDX_W-1:0]      index;
	logic [svm_pkg::CFG_DATA_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/svm_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module svm_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// ===== rtl/svm_front.sv =====
// Front end: accepts items, folds the slot index and forms the voice addends.
module svm_front #(
	parameter int PAINT_SIZE = svm_pkg::PAINT_SIZE_DEF
) (
	svm_in_if.sink                         mix_in,
	input  logic                           q_full,
	input  logic                           clearing,
	output logic                           push,
	output svm_pkg::svm_work_t             push_work,
	output logic [$clog2(PAINT_SIZE)-1:0]  push_idx
);
	import svm_pkg::*;

	localparam int IDX_W = $clog2(PAINT_SIZE);
	localparam int MUL_A_W = ADD_W;
	localparam int MUL_B_W = VOL_W + 1;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	// Slot modulo the buffer size by shifted compare and subtract steps.
	function automatic logic [SLOT_W-1:0] slot_fold(input logic [SLOT_W-1:0] s);
		logic [SLOT_W-1:0] r;
		r = s;
		for (int k = SLOT_W - 1; k >= 0; k--) begin
			if ((PAINT_SIZE << k) < (1 << SLOT_W)) begin
				if (r >= SLOT_W'(PAINT_SIZE << k)) begin
					r = r - SLOT_W'(PAINT_SIZE << k);
				end
			end
		end
		return r;
	endfunction

	function automatic logic [7:0] byte_gain(input logic [VOL_W-1:0] vol);
		logic [7:0] g;
		g = (vol > VOL_W'(BYTE_GAIN_CAP)) ? BYTE_GAIN_CAP : vol[7:0];
		return g & BYTE_GAIN_MASK;
	endfunction

	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_bl;
	logic signed [MUL_B_W-1:0] mul_br;
	logic signed [MUL_P_W-1:0] prod_l;
	logic signed [MUL_P_W-1:0] prod_r;

	assign mix_in.ready = !q_full && !clearing;
	assign push = mix_in.valid && mix_in.ready;
	assign push_idx = IDX_W'(slot_fold(mix_in.slot));

	// Byte and word samples share one multiplier per channel.
	always_comb begin
		if (mix_in.sample_is_byte) begin
			mul_a  = MUL_A_W'($signed(mix_in.sample[7:0]));
			mul_bl = $signed({2'b00, byte_gain(mix_in.left_volume)});
			mul_br = $signed({2'b00, byte_gain(mix_in.right_volume)});
		end else begin
			mul_a  = MUL_A_W'(mix_in.sample);
			mul_bl = $signed({1'b0, mix_in.left_volume});
			mul_br = $signed({1'b0, mix_in.right_volume});
		end
		prod_l = mul_a * mul_bl;
		prod_r = mul_a * mul_br;

		push_work.op = mix_in.op;
		if (mix_in.sample_is_byte) begin
			push_work.add_l = prod_l[ADD_W-1:0];
			push_work.add_r = prod_r[ADD_W-1:0];
		end else begin
			push_work.add_l = prod_l[ADD_W+7:8];
			push_work.add_r = prod_r[ADD_W+7:8];
		end
	end
endmodule

// ===== rtl/svm_queue.sv =====
// Small FIFO between the front end and the back end.
module svm_queue #(
	parameter int WIDTH = 35,
	parameter int DEPTH = svm_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             empty,
	output logic             full
);
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = PTR_W + 1;

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign empty = (count_q == '0);
	assign full = (count_q == CNT_W'(DEPTH));
	assign pop_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end
endmodule

// ===== rtl/svm_back.sv =====
// Back end: read-modify-write of the mix buffer, drain scaling and output format.
module svm_back #(
	parameter int PAINT_SIZE = svm_pkg::PAINT_SIZE_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  svm_pkg::svm_cfg_t              cfg,
	input  logic                           q_empty,
	input  logic [$clog2(PAINT_SIZE)-1:0]  head_idx,
	input  svm_pkg::svm_work_t             head_work,
	output logic                           pop,
	output logic                           clearing,
	svm_out_if.source                      mix_out
);
	import svm_pkg::*;

	localparam int IDX_W = $clog2(PAINT_SIZE);
	localparam int PAIR_W = 2 * ACC_W;
	localparam int V_W = PROD_W - 8;

	localparam logic [1:0] B_IDLE = 2'd0;
	localparam logic [1:0] B_ACC  = 2'd1;
	localparam logic [1:0] B_FMT  = 2'd2;

	function automatic logic [OUT_W-1:0] sat16(input logic signed [PROD_W-1:0] p);
		logic signed [V_W-1:0] v;
		v = p[PROD_W-1:8];
		if (v > V_W'(SAT_HI)) begin
			return SAT_MAX;
		end else if (v < V_W'(SAT_LO)) begin
			return SAT_MIN;
		end
		return v[OUT_W-1:0];
	endfunction

	function automatic logic [OUT_W-1:0] to_byte(input logic [OUT_W-1:0] s);
		return {8'h00, s[OUT_W-1:8] ^ BYTE_BIAS};
	endfunction

	logic [1:0]             state_q;
	logic                   clr_active_q;
	logic [IDX_W-1:0]       clr_addr_q;
	logic [IDX_W-1:0]       cur_idx_q;
	svm_work_t              cur_work_q;
	logic signed [PROD_W-1:0] prod_l_s2;
	logic signed [PROD_W-1:0] prod_r_s2;
	logic                   out_valid_q;
	logic [OUT_W-1:0]       left_q;
	logic [OUT_W-1:0]       right_q;

	logic                   ram_we;
	logic [IDX_W-1:0]       ram_waddr;
	logic [PAIR_W-1:0]      ram_wdata;
	logic                   ram_re;
	logic [PAIR_W-1:0]      ram_rdata;
	logic signed [ACC_W-1:0] acc_l;
	logic signed [ACC_W-1:0] acc_r;
	logic                   load_out;
	logic [OUT_W-1:0]       sat_l;
	logic [OUT_W-1:0]       sat_r;
	logic [OUT_W-1:0]       fmt_l;
	logic [OUT_W-1:0]       fmt_r;

	svm_ram #(
		.WIDTH(PAIR_W),
		.DEPTH(PAINT_SIZE)
	) u_mix_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(head_idx),
		.rdata(ram_rdata)
	);

	assign acc_l = ram_rdata[PAIR_W-1:ACC_W];
	assign acc_r = ram_rdata[ACC_W-1:0];
	assign clearing = clr_active_q;
	assign mix_out.valid = out_valid_q;
	assign mix_out.left_out = left_q;
	assign mix_out.right_out = right_q;

	always_comb begin
		pop = 1'b0;
		ram_re = 1'b0;
		ram_we = 1'b0;
		ram_waddr = cur_idx_q;
		ram_wdata = '0;
		load_out = 1'b0;
		if (clr_active_q) begin
			ram_we = 1'b1;
			ram_waddr = clr_addr_q;
		end else begin
			unique case (state_q)
				B_IDLE: begin
					pop = !q_empty;
					ram_re = !q_empty;
				end
				B_ACC: begin
					// A drain leaves the slot at zero.
					ram_we = 1'b1;
					if (cur_work_q.op == OP_MIX) begin
						ram_wdata = {acc_l + ACC_W'(cur_work_q.add_l),
							acc_r + ACC_W'(cur_work_q.add_r)};
					end
				end
				B_FMT: begin
					load_out = !out_valid_q || mix_out.ready;
				end
				default: begin
				end
			endcase
		end
	end

	// Swap applies only to 16-bit stereo output.
	always_comb begin
		sat_l = sat16(prod_l_s2);
		sat_r = sat16(prod_r_s2);
		if (cfg.mono_output) begin
			fmt_l = cfg.output_bytes ? to_byte(sat_l) : sat_l;
			fmt_r = '0;
		end else if (cfg.output_bytes) begin
			fmt_l = to_byte(sat_l);
			fmt_r = to_byte(sat_r);
		end else if (cfg.swap_stereo) begin
			fmt_l = sat_r;
			fmt_r = sat_l;
		end else begin
			fmt_l = sat_l;
			fmt_r = sat_r;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			clr_active_q <= 1'b1;
			clr_addr_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (clr_active_q) begin
				clr_addr_q <= clr_addr_q + IDX_W'(1);
				if (clr_addr_q == IDX_W'(PAINT_SIZE - 1)) begin
					clr_active_q <= 1'b0;
				end
			end
			unique case (state_q)
				B_IDLE: begin
					if (pop) begin
						state_q <= B_ACC;
					end
				end
				B_ACC: begin
					state_q <= (cur_work_q.op == OP_DRAIN) ? B_FMT : B_IDLE;
				end
				B_FMT: begin
					if (load_out) begin
						state_q <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (mix_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_idx_q <= head_idx;
			cur_work_q <= head_work;
		end
		if (state_q == B_ACC) begin
			prod_l_s2 <= acc_l * $signed({1'b0, cfg.master_volume});
			prod_r_s2 <= acc_r * $signed({1'b0, cfg.master_volume});
		end
		if (load_out) begin
			left_q <= fmt_l;
			right_q <= fmt_r;
		end
	end
endmodule

// ===== rtl/stereo_voice_mix_accumulator_top.sv =====
// Mix accumulates one voice sample per slot; a drain result passes the queue, the registered
// RAM read, the scaling register and the output register. A mix passes the back end as a
// registered RAM read and the write-back; a drain adds the output stage, which waits while
// the output is held. A four-entry queue lets the input side run up to four items ahead of
// the back end. Reset sets the control registers at once, then clears the buffer one slot a
// cycle, during which no item is taken; register writes are taken at any time.
`include "assert_macros.svh"

module stereo_voice_mix_accumulator_top #(
	parameter int PAINT_SIZE = svm_pkg::PAINT_SIZE_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	svm_in_if.sink     mix_in,
	svm_out_if.source  mix_out,
	svm_cfg_if.sink    cfg
);
	import svm_pkg::*;

	localparam int IDX_W = $clog2(PAINT_SIZE);
	localparam int WORK_W = $bits(svm_work_t);
	localparam int ITEM_W = WORK_W + IDX_W;

	svm_cfg_t          cfg_q;
	logic              push;
	svm_work_t         push_work;
	logic [IDX_W-1:0]  push_idx;
	logic              pop;
	logic [ITEM_W-1:0] head_item;
	logic              q_empty;
	logic              q_full;
	logic              clearing;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.master_volume <= MASTER_RESET;
			cfg_q.swap_stereo <= 1'b0;
			cfg_q.output_bytes <= 1'b0;
			cfg_q.mono_output <= 1'b0;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_MASTER_VOLUME: cfg_q.master_volume <= cfg.data[VOL_W-1:0];
				REG_SWAP_STEREO:   cfg_q.swap_stereo <= cfg.data[0];
				REG_OUTPUT_BYTES:  cfg_q.output_bytes <= cfg.data[0];
				REG_MONO_OUTPUT:   cfg_q.mono_output <= cfg.data[0];
				default: begin
				end
			endcase
		end
	end

	svm_front #(
		.PAINT_SIZE(PAINT_SIZE)
	) u_front (
		.mix_in   (mix_in),
		.q_full   (q_full),
		.clearing (clearing),
		.push     (push),
		.push_work(push_work),
		.push_idx (push_idx)
	);

	svm_queue #(
		.WIDTH(ITEM_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data({push_idx, push_work}),
		.pop      (pop),
		.pop_data (head_item),
		.empty    (q_empty),
		.full     (q_full)
	);

	svm_back #(
		.PAINT_SIZE(PAINT_SIZE)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_empty  (q_empty),
		.head_idx (head_item[ITEM_W-1 -: IDX_W]),
		.head_work(svm_work_t'(head_item[WORK_W-1:0])),
		.pop      (pop),
		.clearing (clearing),
		.mix_out  (mix_out)
	);

	// Nothing may enter while the buffer is still being cleared.
	`SVM_ASSERT_IMPL(a_no_accept_clearing, clk, arst_n, clearing, !mix_in.ready)
	`SVM_ASSERT_IMPL(a_queue_idle_clearing, clk, arst_n, clearing, q_empty)
	`SVM_ASSERT_NEXT(a_accept_queued, clk, arst_n, mix_in.valid && mix_in.ready, !q_empty)
	`SVM_ASSERT_IMPL(a_no_pop_empty, clk, arst_n, pop, !q_empty && !clearing)

endmodule
